// ===== rtl/cds_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package cds_pkg;

  localparam int YEAR_W     = 14;
  localparam int DAY_W      = 5;
  localparam int MONTH_W    = 4;
  localparam int OFFSET_W   = 23;
  localparam int COUNT_W    = 22;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [YEAR_W-1:0]  MAX_YEAR       = 14'd9999;
  localparam logic [YEAR_W-1:0]  EARLIEST_RESET = 14'd1582;
  localparam logic [MONTH_W-1:0] MONTH_JAN      = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB      = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC      = 4'd12;
  localparam logic [DAY_W-1:0]   DAY_FIRST      = 5'd1;
  localparam logic [DAY_W-1:0]   DAY_LAST_DEC   = 5'd31;

  // register index of earliest_year
  localparam logic REG_EARLIEST = 1'b0;

  typedef enum logic {
    ACT_ADD  = 1'b0,
    ACT_DIFF = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_BAD_A = 2'd1,
    ST_BAD_B = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  localparam logic [1:0] ORDER_EQ     = 2'b00;
  localparam logic [1:0] ORDER_AFTER  = 2'b01;
  localparam logic [1:0] ORDER_BEFORE = 2'b11;

  typedef struct packed {
    action_t              action;
    status_t              status;
    logic [1:0]           order;
    logic                 backward;
    logic [DAY_W-1:0]     cur_d;
    logic [MONTH_W-1:0]   cur_m;
    logic [YEAR_W-1:0]    cur_y;
    logic [DAY_W-1:0]     tgt_d;
    logic [MONTH_W-1:0]   tgt_m;
    logic [YEAR_W-1:0]    tgt_y;
    logic [OFFSET_W-1:0]  steps;
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_LEAP,
    BK_STEP,
    BK_FINISH
  } back_state_t;

  // y / 100 by reciprocal (exact for y below 16384), then y % 100 == 0 by shift-add compare
  function automatic logic is_leap(input logic [YEAR_W-1:0] y);
    logic [26:0]       prod;
    logic [7:0]        q;
    logic [YEAR_W-1:0] hund;
    prod = 27'(y) * 27'(13'd5243);
    q    = prod[26:19];
    hund = 14'({q, 6'b0}) + 14'({q, 5'b0}) + 14'({q, 2'b0});
    return (y[1:0] == 2'b00) && ((hund != y) || (q[1:0] == 2'b00));
  endfunction

  function automatic logic [DAY_W-1:0] days_in_month(input logic [MONTH_W-1:0] m,
                                                     input logic leap);
    logic [DAY_W-1:0] n;
    unique case (m)
      4'd2:                     n = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:  n = 5'd30;
      default:                  n = 5'd31;
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/cds_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface cds_req_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [4:0]  day_a;
  logic [3:0]  month_a;
  logic [13:0] year_a;
  logic [4:0]  day_b;
  logic [3:0]  month_b;
  logic [13:0] year_b;
  logic signed [22:0] offset;

  modport source (output valid, action, day_a, month_a, year_a, day_b, month_b, year_b,
                  offset, input ready);
  modport sink (input valid, action, day_a, month_a, year_a, day_b, month_b, year_b,
                offset, output ready);
endinterface
`default_nettype wire

// ===== rtl/cds_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface cds_rsp_if;
  logic        valid;
  logic        ready;
  logic [4:0]  day_out;
  logic [3:0]  month_out;
  logic [13:0] year_out;
  logic [21:0] day_count;
  logic signed [1:0] order;
  logic [1:0]  status;

  modport source (output valid, day_out, month_out, year_out, day_count, order, status,
                  input ready);
  modport sink (input valid, day_out, month_out, year_out, day_count, order, status,
                output ready);
endinterface
`default_nettype wire

// ===== rtl/calendar_date_stepper_core.sv =====
// Each accepted word passes the front stage register, the job queue and the back end,
//   whose FSM steps |offset| days, or the day difference, one day at a time, and
//   recomputes the leap year at each year boundary crossed; this stepper sets the throughput.
// A two-entry job queue lets the front end classify the next word meanwhile.
// Reset (rst, synchronous, active high) empties the front stage, the queue and the
//   result register, and sets earliest_year to 1582.
`timescale 1ns / 1ps
`default_nettype none
module calendar_date_stepper_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                           clk,
  input  logic                           rst,
  cds_req_if.sink                        req,
  cds_rsp_if.source                      rsp,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [cds_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [cds_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [cds_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import cds_pkg::*;

  logic [YEAR_W-1:0] earliest_year;
  logic              fq_valid;
  logic              fq_ready;
  job_t              fq_job;
  logic              qb_valid;
  logic              qb_ready;
  job_t              qb_job;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_EARLIEST) ? CFG_DATA_W'(earliest_year) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      earliest_year <= EARLIEST_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_EARLIEST)) begin
      earliest_year <= pwdata[YEAR_W-1:0];
    end
  end

  cds_front u_front (
    .clk           (clk),
    .rst           (rst),
    .req           (req),
    .earliest_year (earliest_year),
    .job_valid     (fq_valid),
    .job           (fq_job),
    .job_ready     (fq_ready)
  );

  cds_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_job   (fq_job),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_job    (qb_job)
  );

  cds_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (qb_valid),
    .job_ready (qb_ready),
    .job       (qb_job),
    .rsp       (rsp)
  );

endmodule
`default_nettype wire

// ===== rtl/cds_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module cds_front (
  input  logic                       clk,
  input  logic                       rst,
  cds_req_if.sink                    req,
  input  logic [cds_pkg::YEAR_W-1:0] earliest_year,
  output logic                       job_valid,
  output cds_pkg::job_t              job,
  input  logic                       job_ready
);
  import cds_pkg::*;

  logic                s1_valid;
  logic                s1_action;
  logic [DAY_W-1:0]    s1_day_a;
  logic [MONTH_W-1:0]  s1_month_a;
  logic [YEAR_W-1:0]   s1_year_a;
  logic [DAY_W-1:0]    s1_day_b;
  logic [MONTH_W-1:0]  s1_month_b;
  logic [YEAR_W-1:0]   s1_year_b;
  logic [OFFSET_W-1:0] s1_offset;

  logic                valid_a;
  logic                valid_b;
  logic [DAY_W-1:0]    dim_a;
  logic [DAY_W-1:0]    dim_b;
  logic [22:0]         key_a;
  logic [22:0]         key_b;

  assign req.ready = !s1_valid || job_ready;
  assign job_valid = s1_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_action  <= req.action;
      s1_day_a   <= req.day_a;
      s1_month_a <= req.month_a;
      s1_year_a  <= req.year_a;
      s1_day_b   <= req.day_b;
      s1_month_b <= req.month_b;
      s1_year_b  <= req.year_b;
      s1_offset  <= req.offset;
    end
  end

  always_comb begin
    dim_a   = days_in_month(s1_month_a, is_leap(s1_year_a));
    dim_b   = days_in_month(s1_month_b, is_leap(s1_year_b));
    valid_a = (s1_year_a >= earliest_year) && (s1_year_a <= MAX_YEAR) &&
              (s1_month_a >= MONTH_JAN) && (s1_month_a <= MONTH_DEC) &&
              (s1_day_a >= DAY_FIRST) && (s1_day_a <= dim_a);
    valid_b = (s1_year_b >= earliest_year) && (s1_year_b <= MAX_YEAR) &&
              (s1_month_b >= MONTH_JAN) && (s1_month_b <= MONTH_DEC) &&
              (s1_day_b >= DAY_FIRST) && (s1_day_b <= dim_b);
    key_a   = {s1_year_a, s1_month_a, s1_day_a};
    key_b   = {s1_year_b, s1_month_b, s1_day_b};
  end

  // classify: the back end only steps from cur toward tgt, or counts down steps
  always_comb begin
    job        = '0;
    job.action = action_t'(s1_action);
    job.status = ST_OK;
    if (!valid_a) begin
      job.status = ST_BAD_A;
    end else if (job.action == ACT_ADD) begin
      job.cur_d    = s1_day_a;
      job.cur_m    = s1_month_a;
      job.cur_y    = s1_year_a;
      job.backward = s1_offset[OFFSET_W-1];
      job.steps    = s1_offset[OFFSET_W-1] ? OFFSET_W'(-s1_offset) : s1_offset;
    end else if (!valid_b) begin
      job.status = ST_BAD_B;
    end else if (key_a < key_b) begin
      job.order = ORDER_BEFORE;
      job.cur_d = s1_day_a;
      job.cur_m = s1_month_a;
      job.cur_y = s1_year_a;
      job.tgt_d = s1_day_b;
      job.tgt_m = s1_month_b;
      job.tgt_y = s1_year_b;
    end else if (key_a > key_b) begin
      job.order = ORDER_AFTER;
      job.cur_d = s1_day_b;
      job.cur_m = s1_month_b;
      job.cur_y = s1_year_b;
      job.tgt_d = s1_day_a;
      job.tgt_m = s1_month_a;
      job.tgt_y = s1_year_a;
    end else begin
      job.order = ORDER_EQ;
      job.cur_d = s1_day_a;
      job.cur_m = s1_month_a;
      job.cur_y = s1_year_a;
      job.tgt_d = s1_day_b;
      job.tgt_m = s1_month_b;
      job.tgt_y = s1_year_b;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/cds_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module cds_queue #(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  cds_pkg::job_t push_job,
  output logic          pop_valid,
  input  logic          pop_ready,
  output cds_pkg::job_t pop_job
);
  import cds_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (fill != CNT_W'(DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_job    = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/cds_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module cds_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          job_valid,
  output logic          job_ready,
  input  cds_pkg::job_t job,
  cds_rsp_if.source     rsp
);
  import cds_pkg::*;

  back_state_t         state;
  back_state_t         state_next;

  action_t             act;
  status_t             status;
  logic [1:0]          order;
  logic                backward;
  logic                leap;
  logic [DAY_W-1:0]    cur_d;
  logic [MONTH_W-1:0]  cur_m;
  logic [YEAR_W-1:0]   cur_y;
  logic [DAY_W-1:0]    tgt_d;
  logic [MONTH_W-1:0]  tgt_m;
  logic [YEAR_W-1:0]   tgt_y;
  logic [OFFSET_W-1:0] cnt;

  logic [DAY_W-1:0]    cur_d_next;
  logic [MONTH_W-1:0]  cur_m_next;
  logic [YEAR_W-1:0]   cur_y_next;
  logic [DAY_W-1:0]    dim;
  logic [MONTH_W-1:0]  prev_m;
  logic                at_end;
  logic                at_edge;
  logic                year_wrap;
  logic                out_free;
  logic                load_out;

  logic                out_valid;
  logic [DAY_W-1:0]    out_day;
  logic [MONTH_W-1:0]  out_month;
  logic [YEAR_W-1:0]   out_year;
  logic [COUNT_W-1:0]  out_count;
  logic [1:0]          out_order;
  logic [1:0]          out_status;

  assign rsp.valid     = out_valid;
  assign rsp.day_out   = out_day;
  assign rsp.month_out = out_month;
  assign rsp.year_out  = out_year;
  assign rsp.day_count = out_count;
  assign rsp.order     = out_order;
  assign rsp.status    = out_status;

  assign out_free = !out_valid || rsp.ready;

  // one-day step, forward or backward
  always_comb begin
    dim    = days_in_month(cur_m, leap);
    prev_m = cur_m - 1'b1;
    at_end = (act == ACT_ADD) ? (cnt == '0)
                              : ((cur_d == tgt_d) && (cur_m == tgt_m) && (cur_y == tgt_y));
    cur_d_next = cur_d;
    cur_m_next = cur_m;
    cur_y_next = cur_y;
    year_wrap  = 1'b0;
    if (!backward) begin
      at_edge = (cur_y == MAX_YEAR) && (cur_m == MONTH_DEC) && (cur_d == DAY_LAST_DEC);
      if (cur_d == dim) begin
        cur_d_next = DAY_FIRST;
        if (cur_m == MONTH_DEC) begin
          cur_m_next = MONTH_JAN;
          cur_y_next = cur_y + 1'b1;
          year_wrap  = 1'b1;
        end else begin
          cur_m_next = cur_m + 1'b1;
        end
      end else begin
        cur_d_next = cur_d + 1'b1;
      end
    end else begin
      at_edge = (cur_y == '0) && (cur_m == MONTH_JAN) && (cur_d == DAY_FIRST);
      if (cur_d == DAY_FIRST) begin
        if (cur_m == MONTH_JAN) begin
          cur_d_next = DAY_LAST_DEC;
          cur_m_next = MONTH_DEC;
          cur_y_next = cur_y - 1'b1;
          year_wrap  = 1'b1;
        end else begin
          cur_d_next = days_in_month(prev_m, leap);
          cur_m_next = prev_m;
        end
      end else begin
        cur_d_next = cur_d - 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (job_valid) begin
          state_next = (job.status != ST_OK) ? BK_FINISH : BK_LEAP;
        end
      end
      BK_LEAP: begin
        state_next = BK_STEP;
      end
      BK_STEP: begin
        if (at_end || at_edge) begin
          state_next = BK_FINISH;
        end else if (year_wrap) begin
          state_next = BK_LEAP;
        end
      end
      BK_FINISH: begin
        if (out_free) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    job_ready = (state == BK_IDLE);
    load_out  = (state == BK_FINISH) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      BK_IDLE: begin
        if (job_valid) begin
          act      <= job.action;
          status   <= job.status;
          order    <= job.order;
          backward <= job.backward;
          cur_d    <= job.cur_d;
          cur_m    <= job.cur_m;
          cur_y    <= job.cur_y;
          tgt_d    <= job.tgt_d;
          tgt_m    <= job.tgt_m;
          tgt_y    <= job.tgt_y;
          cnt      <= (job.action == ACT_ADD) ? job.steps : '0;
        end
      end
      BK_LEAP: begin
        leap <= is_leap(cur_y);
      end
      BK_STEP: begin
        if (!at_end) begin
          if (at_edge) begin
            status <= ST_RANGE;
          end else begin
            cur_d <= cur_d_next;
            cur_m <= cur_m_next;
            cur_y <= cur_y_next;
            cnt   <= (act == ACT_ADD) ? cnt - 1'b1 : cnt + 1'b1;
          end
        end
      end
      BK_FINISH: begin
        if (out_free) begin
          out_status <= status;
          if ((status == ST_OK) && (act == ACT_ADD)) begin
            out_day   <= cur_d;
            out_month <= cur_m;
            out_year  <= cur_y;
          end else begin
            out_day   <= '0;
            out_month <= '0;
            out_year  <= '0;
          end
          if ((status == ST_OK) && (act == ACT_DIFF)) begin
            out_count <= cnt[COUNT_W-1:0];
            out_order <= order;
          end else begin
            out_count <= '0;
            out_order <= ORDER_EQ;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/cds_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module cds_checker (
  input logic        clk,
  input logic        rst,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [4:0]  day_out,
  input logic [3:0]  month_out,
  input logic [13:0] year_out,
  input logic [21:0] day_count,
  input logic [1:0]  order,
  input logic [1:0]  status
);

  // a stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable({day_out, month_out, year_out,
                                                      day_count, order, status}))
    else $error("result word dropped or changed while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid right after reset");

  // an error word carries nothing else
  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status != 2'd0) |-> (day_out == '0) && (month_out == '0) &&
      (year_out == '0) && (day_count == '0) && (order == 2'b00))
    else $error("error word with payload");

  // add results and difference results never mix
  a_kind: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == 2'd0) && (month_out != '0) |->
      (day_count == '0) && (order == 2'b00) && (day_out != '0))
    else $error("date result mixed with difference fields");

  a_order: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (order != 2'b10) && ((order == 2'b00) == (day_count == '0) ||
      (month_out != '0)))
    else $error("order and day count disagree");

endmodule

bind calendar_date_stepper_core cds_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .day_out   (rsp.day_out),
  .month_out (rsp.month_out),
  .year_out  (rsp.year_out),
  .day_count (rsp.day_count),
  .order     (rsp.order),
  .status    (rsp.status)
);
`default_nettype wire
